// File: src/pnfe_pkg.sv
// pnfe_pkg: sizes, request codes and helper functions for the petri net firing engine
// no dependencies; imported by petri_net_firing_engine_core and tb_top

package pnfe_pkg;

	localparam int unsigned MAX_PLACES      = 32;
	localparam int unsigned MAX_TRANSITIONS = 32;
	localparam int unsigned TOKEN_BITS      = 16;

	localparam int unsigned PLACE_BITS = $clog2(MAX_PLACES);
	localparam int unsigned TRANS_BITS = $clog2(MAX_TRANSITIONS);
	localparam int unsigned ARC_CELLS  = MAX_TRANSITIONS * MAX_PLACES;
	localparam int unsigned ARC_BITS   = TRANS_BITS + PLACE_BITS;
	localparam int unsigned WEIGHT_BITS = 8;
	localparam int unsigned CFG_BITS    = 6;
	localparam int unsigned VAL_BITS    = 16;

	localparam logic [2:0] REQ_CLEAR    = 3'd0;
	localparam logic [2:0] REQ_LOAD_TOK = 3'd1;
	localparam logic [2:0] REQ_LOAD_IN  = 3'd2;
	localparam logic [2:0] REQ_LOAD_OUT = 3'd3;
	localparam logic [2:0] REQ_RUN      = 3'd4;

	localparam logic CFG_PLACES = 1'b0;
	localparam logic CFG_TRANS  = 1'b1;

	typedef logic [TOKEN_BITS-1:0] token_t;
	typedef logic [WEIGHT_BITS-1:0] weight_t;

	// highest index in use: zero counts as one, oversize counts as the maximum
	function automatic logic [CFG_BITS-1:0] clamp_last(input logic [CFG_BITS-1:0] v,
			input logic [CFG_BITS:0] top);
		logic [CFG_BITS-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if ({1'b0, v} > top) begin
			r = CFG_BITS'(top - 1'b1);
		end else begin
			r = v - 1'b1;
		end
		return r;
	endfunction

	function automatic weight_t sat_weight(input logic [VAL_BITS-1:0] v);
		weight_t r;
		if (v > VAL_BITS'((1 << WEIGHT_BITS) - 1)) begin
			r = '1;
		end else begin
			r = v[WEIGHT_BITS-1:0];
		end
		return r;
	endfunction

	function automatic token_t sat_token(input logic [VAL_BITS-1:0] v);
		logic [VAL_BITS+TOKEN_BITS-1:0] w;
		token_t r;
		w = (VAL_BITS+TOKEN_BITS)'(v);
		if (w > (VAL_BITS+TOKEN_BITS)'({TOKEN_BITS{1'b1}})) begin
			r = '1;
		end else begin
			r = w[TOKEN_BITS-1:0];
		end
		return r;
	endfunction

endpackage

// File: src/petri_net_firing_engine_core.sv
// petri net firing engine: loads are written as they are accepted; a run scans places per transition,
// reading then checking each arc, fires the first enabled transition by reading and updating
// each place in use, then finds the last marked place and lists the summary and marked places
// one request at a time; the next is taken when the last result has entered the output register
// async reset clears the token store and control, then a pass over every cell zeroes both arc tables
// a clear request zeroes the tokens and runs the same pass; configuration writes are taken throughout

module petri_net_firing_engine_core
	import pnfe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_BITS-1:0]   cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            req_type,
	input  logic [4:0]            place_index,
	input  logic [4:0]            transition_index,
	input  logic [15:0]           load_value,
	input  logic [15:0]           firing_limit,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  result_kind,
	output logic                  still_live,
	output logic [15:0]           fired_count,
	output logic [4:0]            place_number,
	output logic [15:0]           place_tokens,
	output logic                  last_of_run
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_NEXT   = 4'd2;
	localparam logic [3:0] S_EN_RD  = 4'd3;
	localparam logic [3:0] S_EN_CHK = 4'd4;
	localparam logic [3:0] S_FI_RD  = 4'd5;
	localparam logic [3:0] S_FI_UPD = 4'd6;
	localparam logic [3:0] S_FIND   = 4'd7;
	localparam logic [3:0] S_SUM    = 4'd8;
	localparam logic [3:0] S_EMIT   = 4'd9;

	logic [3:0]            state_q;
	logic [ARC_BITS-1:0]   clr_cnt_q;
	logic [CFG_BITS-1:0]   np_reg_q;
	logic [CFG_BITS-1:0]   nt_reg_q;
	logic [PLACE_BITS-1:0] np_m1_q;
	logic [TRANS_BITS-1:0] nt_m1_q;
	logic [15:0]           limit_q;
	logic [15:0]           fired_q;
	logic                  live_q;
	logic                  found_q;
	logic [PLACE_BITS-1:0] last_q;
	logic [PLACE_BITS-1:0] p_q;
	logic [TRANS_BITS-1:0] t_q;
	token_t                token_q [MAX_PLACES];

	weight_t               win_mem [ARC_CELLS];
	weight_t               wout_mem [ARC_CELLS];
	weight_t               win_rd_q;
	weight_t               wout_rd_q;

	logic                  out_valid_q;
	logic                  kind_q;
	logic                  live_out_q;
	logic [15:0]           cnt_out_q;
	logic [4:0]            pn_out_q;
	logic [15:0]           tok_out_q;
	logic                  last_out_q;

	logic                  accept;
	logic                  slot_free;
	logic                  clearing;
	logic                  win_we;
	logic                  wout_we;
	logic [ARC_BITS-1:0]   waddr;
	logic [ARC_BITS-1:0]   raddr;
	weight_t               wdata;
	token_t                tok_cur;
	logic [TOKEN_BITS:0]   diff;
	logic [TOKEN_BITS:0]   sum;
	logic                  short_of;
	token_t                tok_upd;
	logic                  out_load;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign clearing  = (state_q == S_CLEAR);

	// shared arithmetic unit: enable test and firing update
	assign tok_cur  = token_q[p_q];
	assign diff     = {1'b0, tok_cur} - (TOKEN_BITS+1)'(win_rd_q);
	assign short_of = diff[TOKEN_BITS];
	assign sum      = {1'b0, diff[TOKEN_BITS-1:0]} + (TOKEN_BITS+1)'(wout_rd_q);
	assign tok_upd  = sum[TOKEN_BITS] ? '1 : sum[TOKEN_BITS-1:0];

	// arc table ports
	assign raddr   = {t_q, p_q};
	assign waddr   = clearing ? clr_cnt_q
		: {TRANS_BITS'(transition_index), PLACE_BITS'(place_index)};
	assign wdata   = clearing ? '0 : sat_weight(load_value);
	assign win_we  = clearing || (accept && req_type == REQ_LOAD_IN);
	assign wout_we = clearing || (accept && req_type == REQ_LOAD_OUT);

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[waddr] <= wdata;
		end
		win_rd_q <= win_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (wout_we) begin
			wout_mem[waddr] <= wdata;
		end
		wout_rd_q <= wout_mem[raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			np_reg_q  <= CFG_BITS'(MAX_PLACES);
			nt_reg_q  <= CFG_BITS'(MAX_TRANSITIONS);
			np_m1_q   <= '0;
			nt_m1_q   <= '0;
			limit_q   <= '0;
			fired_q   <= '0;
			live_q    <= 1'b1;
			found_q   <= 1'b0;
			last_q    <= '0;
			p_q       <= '0;
			t_q       <= '0;
			for (int i = 0; i < MAX_PLACES; i++) begin
				token_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PLACES: np_reg_q <= cfg_wdata;
					CFG_TRANS:  nt_reg_q <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (req_type)
							REQ_CLEAR: begin
								for (int i = 0; i < MAX_PLACES; i++) begin
									token_q[i] <= '0;
								end
								clr_cnt_q <= '0;
								state_q   <= S_CLEAR;
							end
							REQ_LOAD_TOK: begin
								token_q[PLACE_BITS'(place_index)] <= sat_token(load_value);
							end
							REQ_RUN: begin
								np_m1_q <= PLACE_BITS'(clamp_last(np_reg_q,
									(CFG_BITS+1)'(MAX_PLACES)));
								nt_m1_q <= TRANS_BITS'(clamp_last(nt_reg_q,
									(CFG_BITS+1)'(MAX_TRANSITIONS)));
								limit_q <= firing_limit;
								fired_q <= '0;
								live_q  <= 1'b1;
								state_q <= S_NEXT;
							end
							default: ;
						endcase
					end
				end
				S_NEXT: begin
					p_q <= '0;
					t_q <= '0;
					if (fired_q == limit_q) begin
						found_q <= 1'b0;
						state_q <= S_FIND;
					end else begin
						state_q <= S_EN_RD;
					end
				end
				S_EN_RD: begin
					state_q <= S_EN_CHK;
				end
				S_EN_CHK: begin
					if (short_of) begin
						p_q <= '0;
						if (t_q == nt_m1_q) begin
							live_q  <= 1'b0;
							found_q <= 1'b0;
							state_q <= S_FIND;
						end else begin
							t_q     <= t_q + 1'b1;
							state_q <= S_EN_RD;
						end
					end else if (p_q == np_m1_q) begin
						p_q     <= '0;
						state_q <= S_FI_RD;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= S_EN_RD;
					end
				end
				S_FI_RD: begin
					state_q <= S_FI_UPD;
				end
				S_FI_UPD: begin
					token_q[p_q] <= tok_upd;
					if (p_q == np_m1_q) begin
						fired_q <= fired_q + 1'b1;
						state_q <= S_NEXT;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= S_FI_RD;
					end
				end
				S_FIND: begin
					if (tok_cur != '0) begin
						found_q <= 1'b1;
						last_q  <= p_q;
					end
					if (p_q == np_m1_q) begin
						p_q     <= '0;
						state_q <= S_SUM;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				S_SUM: begin
					if (slot_free) begin
						state_q <= found_q ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					if (tok_cur == '0) begin
						p_q <= p_q + 1'b1;
					end else if (slot_free) begin
						if (p_q == last_q) begin
							state_q <= S_IDLE;
						end else begin
							p_q <= p_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	assign out_load = slot_free
		&& ((state_q == S_SUM) || (state_q == S_EMIT && tok_cur != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q     <= (state_q == S_EMIT);
			live_out_q <= (state_q == S_SUM) && live_q;
			cnt_out_q  <= (state_q == S_SUM) ? fired_q : '0;
			pn_out_q   <= (state_q == S_EMIT) ? 5'(p_q) : '0;
			tok_out_q  <= (state_q == S_EMIT) ? 16'(tok_cur) : '0;
			last_out_q <= (state_q == S_SUM) ? !found_q : (p_q == last_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign still_live   = live_out_q;
	assign fired_count  = cnt_out_q;
	assign place_number = pn_out_q;
	assign place_tokens = tok_out_q;
	assign last_of_run  = last_out_q;

`ifndef SYNTH
	a_fired_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fired_q <= limit_q)
		else $error("fired count passed the firing limit");

	a_place_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EN_CHK || state_q == S_FI_UPD || state_q == S_FIND)
		|-> p_q <= np_m1_q)
		else $error("place counter beyond places in use");

	a_place_result_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind) |-> place_tokens != '0)
		else $error("place result with no tokens");

	a_clear_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && clr_cnt_q == '1) |=> state_q == S_IDLE)
		else $error("clearing pass did not return to idle");

	a_fire_only_when_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FI_UPD) |-> !short_of)
		else $error("firing would take more tokens than held");
`endif

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for petri_net_firing_engine_core, the petri net firing engine
// predicts each run (summary plus marked places) and checks every result in order
// depends on pnfe_pkg and petri_net_firing_engine_core only
`timescale 1ns / 1ps

module tb_top;
	import pnfe_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 100_000_000;
	localparam int unsigned SETTLE_CYCLES = 1100;
	localparam int unsigned HOLD_CYCLES   = 2000;
	localparam logic [2:0]  REQ_TOP       = 3'd7;
	localparam logic        KIND_SUMMARY  = 1'b0;
	localparam logic        KIND_PLACE    = 1'b1;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic        kind;
		logic        live;
		logic [15:0] fired;
		logic [4:0]  place;
		logic [15:0] tokens;
		logic        last;
	} run_result_t;

	logic                clk              = 1'b0;
	logic                arst_n           = 1'b0;
	logic                cfg_we           = 1'b0;
	logic                cfg_index        = CFG_PLACES;
	logic [CFG_BITS-1:0] cfg_wdata        = '0;
	logic                in_valid         = 1'b0;
	logic                in_stall;
	logic [2:0]          req_type         = REQ_CLEAR;
	logic [4:0]          place_index      = '0;
	logic [4:0]          transition_index = '0;
	logic [15:0]         load_value       = '0;
	logic [15:0]         firing_limit     = '0;
	logic                out_valid;
	logic                out_stall        = 1'b0;
	logic                result_kind;
	logic                still_live;
	logic [15:0]         fired_count;
	logic [4:0]          place_number;
	logic [15:0]         place_tokens;
	logic                last_of_run;

	// predicted net state
	token_t              marking [MAX_PLACES] = '{default: '0};
	weight_t             in_weight [ARC_CELLS] = '{default: '0};
	weight_t             out_mult [ARC_CELLS] = '{default: '0};
	logic [CFG_BITS-1:0] places_reg = 6'd32;
	logic [CFG_BITS-1:0] trans_reg  = 6'd32;

	run_result_t expected_results[$];

	int unsigned error_count    = 0;
	int unsigned results_seen   = 0;
	int unsigned cycle_count    = 0;
	int unsigned sender_gap_pct = 0;
	int unsigned stall_pct      = 0;
	logic        hold_output    = 1'b0;
	event        hold_request;

	petri_net_firing_engine_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.place_index      (place_index),
		.transition_index (transition_index),
		.load_value       (load_value),
		.firing_limit     (firing_limit),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_kind      (result_kind),
		.still_live       (still_live),
		.fired_count      (fired_count),
		.place_number     (place_number),
		.place_tokens     (place_tokens),
		.last_of_run      (last_of_run)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_output) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// long receiver hold-off
	always begin
		@(hold_request);
		hold_output <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_output <= 1'b0;
	end

	function automatic int unsigned used_count(input logic [CFG_BITS-1:0] v,
			input int unsigned top);
		if (v == '0) return 1;
		if (v > top) return top;
		return int'(v);
	endfunction

	function automatic void add_expected(input run_result_t r);
		expected_results = {expected_results, r};
	endfunction

	task automatic predict_request(input logic [2:0] req, input logic [4:0] pi,
			input logic [4:0] ti, input logic [15:0] val, input logic [15:0] lim);
		int unsigned np, nt, t, p, chosen, arc_idx;
		int          last_marked;
		logic [15:0] fired;
		logic        live, found;
		logic [16:0] sum;
		case (req)
			REQ_CLEAR: begin
				foreach (marking[i]) marking[i] = '0;
				foreach (in_weight[i]) begin
					in_weight[i] = '0;
					out_mult[i] = '0;
				end
			end
			REQ_LOAD_TOK: marking[pi] = token_t'(val);
			REQ_LOAD_IN: in_weight[ti * MAX_PLACES + pi] = (val > 16'd255) ? '1 : weight_t'(val);
			REQ_LOAD_OUT: out_mult[ti * MAX_PLACES + pi] = (val > 16'd255) ? '1 : weight_t'(val);
			REQ_RUN: begin
				np = used_count(places_reg, MAX_PLACES);
				nt = used_count(trans_reg, MAX_TRANSITIONS);
				fired = '0;
				live = 1'b1;
				chosen = 0;
				while (fired < lim && live) begin
					found = 1'b0;
					for (t = 0; t < nt && !found; t++) begin
						found = 1'b1;
						for (p = 0; p < np; p++)
							if (marking[p] < in_weight[t * MAX_PLACES + p]) found = 1'b0;
						if (found) chosen = t;
					end
					if (!found) begin
						live = 1'b0;
					end else begin
						for (p = 0; p < np; p++) begin
							arc_idx = chosen * MAX_PLACES + p;
							sum = marking[p] - in_weight[arc_idx] + out_mult[arc_idx];
							marking[p] = sum[16] ? '1 : sum[15:0];
						end
						fired++;
					end
				end
				last_marked = -1;
				for (p = 0; p < np; p++)
					if (marking[p] != '0) last_marked = int'(p);
				add_expected(run_result_t'({KIND_SUMMARY, live, fired, 5'd0, 16'd0,
					last_marked < 0}));
				for (p = 0; p < np; p++)
					if (marking[p] != '0)
						add_expected(run_result_t'({KIND_PLACE, 1'b0, 16'd0, 5'(p),
							marking[p][15:0], int'(p) == last_marked}));
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (error_count < 50)
			$display("mismatch: %s got %0h expected %0h at result %0d", what, got, want,
				results_seen);
		error_count++;
	endtask

	task automatic check_field(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin : result_check
		run_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {result_kind, still_live, fired_count, place_number, place_tokens, last_of_run};
			if (expected_results.size() == 0) begin
				report_mismatch("result with none outstanding, tokens", got.tokens, '0);
			end else begin
				want = expected_results.pop_front();
				check_field("result_kind", 16'(got.kind), 16'(want.kind));
				check_field("still_live", 16'(got.live), 16'(want.live));
				check_field("fired_count", got.fired, want.fired);
				check_field("place_number", 16'(got.place), 16'(want.place));
				check_field("place_tokens", got.tokens, want.tokens);
				check_field("last_of_run", 16'(got.last), 16'(want.last));
			end
			results_seen++;
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		sender_gap_pct = (mode == IDLE_SENDER) ? 88 : (mode == IDLE_BOTH) ? 28 : 0;
		stall_pct <= (mode == IDLE_RECEIVER) ? 88 : (mode == IDLE_BOTH) ? 28 : 0;
	endtask

	task automatic send_request(input logic [2:0] req, input logic [4:0] pi,
			input logic [4:0] ti, input logic [15:0] val, input logic [15:0] lim);
		if ($urandom_range(99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_gap_pct);
		end
		in_valid <= 1'b1;
		req_type <= req;
		place_index <= pi;
		transition_index <= ti;
		load_value <= val;
		firing_limit <= lim;
		do @(posedge clk); while (in_stall);
		predict_request(req, pi, ti, val, lim);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// only written once every outstanding request has finished
	task automatic write_net_size(input logic [CFG_BITS-1:0] places,
			input logic [CFG_BITS-1:0] trans);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PLACES;
		cfg_wdata <= places;
		@(posedge clk);
		cfg_index <= CFG_TRANS;
		cfg_wdata <= trans;
		@(posedge clk);
		cfg_we <= 1'b0;
		places_reg = places;
		trans_reg = trans;
	endtask

	task automatic test_loads_and_first_run();
		set_idling(IDLE_NONE);
		send_request(REQ_RUN, '0, '0, '0, 16'd0);
		send_request(REQ_LOAD_TOK, 5'd0, 5'd0, 16'hFFFF, '0);
		send_request(REQ_LOAD_TOK, 5'd31, 5'd31, 16'd1, 16'hFFFF);
		send_request(REQ_LOAD_TOK, 5'd5, 5'd0, 16'd300, '0);
		send_request(REQ_LOAD_IN, 5'd31, 5'd0, 16'hFFFF, '0);
		send_request(REQ_LOAD_IN, 5'd5, 5'd1, 16'd255, '0);
		send_request(REQ_LOAD_OUT, 5'd0, 5'd1, 16'd200, '0);
		send_request(REQ_LOAD_OUT, 5'd30, 5'd1, 16'h0107, '0);
		send_request(REQ_RUN, 5'd31, 5'd31, 16'hFFFF, 16'd2);
		send_request(REQ_RUN + 3'd1, 5'd7, 5'd3, 16'h1234, 16'd9);
		send_request(REQ_TOP, 5'd31, 5'd31, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_dead_net();
		write_net_size(6'd3, 6'd2);
		send_request(REQ_CLEAR, '0, '0, '0, '0);
		send_request(REQ_LOAD_TOK, 5'd0, 5'd0, 16'd5, '0);
		send_request(REQ_LOAD_TOK, 5'd20, 5'd0, 16'd9, '0);
		send_request(REQ_LOAD_IN, 5'd0, 5'd0, 16'd1, '0);
		send_request(REQ_LOAD_OUT, 5'd1, 5'd0, 16'd1, '0);
		send_request(REQ_LOAD_IN, 5'd1, 5'd1, 16'd1, '0);
		send_request(REQ_LOAD_OUT, 5'd2, 5'd1, 16'd1, '0);
		send_request(REQ_RUN, '0, '0, '0, 16'hFFFF);
	endtask

	// zero-sized net counts as one place and one transition
	task automatic test_saturating_run();
		write_net_size(6'd0, 6'd0);
		send_request(REQ_CLEAR, 5'd31, 5'd31, 16'hFFFF, 16'hFFFF);
		send_request(REQ_LOAD_TOK, 5'd0, 5'd0, 16'd1, '0);
		send_request(REQ_LOAD_IN, 5'd0, 5'd0, 16'd1, '0);
		send_request(REQ_LOAD_OUT, 5'd0, 5'd0, 16'd2, '0);
		send_request(REQ_RUN, '0, '0, '0, 16'hFFFF);
	endtask

	task automatic test_random_traffic(input idle_mode_t mode,
			input logic [CFG_BITS-1:0] places, input logic [CFG_BITS-1:0] trans,
			input int unsigned count);
		int unsigned np, nt, pick, accepted;
		logic [2:0]  req;
		logic [4:0]  pi, ti;
		logic [15:0] val, lim;
		write_net_size(places, trans);
		set_idling(mode);
		np = used_count(places, MAX_PLACES);
		nt = used_count(trans, MAX_TRANSITIONS);
		accepted = 0;
		while (accepted < count) begin
			pick = $urandom_range(99);
			pi = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(np - 1));
			case ($urandom_range(4))
				0, 1: ti = 5'($urandom_range((nt < 4) ? nt - 1 : 3));
				2, 3: ti = 5'($urandom_range(nt - 1));
				default: ti = 5'($urandom_range(31));
			endcase
			val = 16'($urandom);
			lim = 16'($urandom);
			if (pick < 3) begin
				req = REQ_CLEAR;
			end else if (pick < 28) begin
				req = REQ_LOAD_TOK;
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: val = 16'($urandom_range(10));
					6, 7: ;
					default: val = 16'hFFFF - 16'($urandom_range(1));
				endcase
			end else if (pick < 72) begin
				req = (pick < 50) ? REQ_LOAD_IN : REQ_LOAD_OUT;
				case ($urandom_range(19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: val = 16'($urandom_range(2));
					12, 13, 14, 15, 16: val = 16'($urandom_range(255));
					default: ;
				endcase
			end else if (pick < 94) begin
				req = REQ_RUN;
				lim = ($urandom_range(4) == 0) ? 16'($urandom_range(64)) : 16'($urandom_range(8));
			end else begin
				req = 3'($urandom_range(REQ_RUN + 1, REQ_TOP));
			end
			send_request(req, pi, ti, val, lim);
			if (req <= REQ_RUN) accepted++;
		end
	endtask

	// receiver holds off while runs keep arriving, then the sender waits for the backlog
	task automatic test_output_hold();
		set_idling(IDLE_NONE);
		for (int p = 0; p < 4; p++)
			send_request(REQ_LOAD_TOK, 5'(p * 3), '0, 16'(p + 1), '0);
		-> hold_request;
		repeat (8) send_request(REQ_RUN, '0, '0, '0, 16'($urandom_range(3)));
		wait_for_results();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_loads_and_first_run();
		test_dead_net();
		test_saturating_run();
		test_random_traffic(IDLE_NONE, 6'd8, 6'd4, 120);
		test_random_traffic(IDLE_SENDER, 6'd63, 6'd32, 120);
		test_output_hold();
		test_random_traffic(IDLE_RECEIVER, 6'd1, 6'd1, 120);
		test_random_traffic(IDLE_BOTH, 6'($urandom_range(63)), 6'($urandom_range(63)), 120);
		test_random_traffic(IDLE_RECEIVER, 6'd32, 6'd33, 40);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
